// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("implication failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("never");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- design/veb_pkg.sv -----
// Package: widths, constants and child-index helpers for the vEB layout search.
package veb_pkg;
    localparam int CapLog2   = 16;
    localparam int MaxLevels = CapLog2 + 1;
    localparam int RootSlots = 16;
    localparam int IdxW      = CapLog2;
    localparam int LvlW      = 5;
    localparam int ValW      = 32;
    localparam int CntW      = 16;

    typedef logic [IdxW-1:0] t_idx;
    typedef logic [LvlW-1:0] t_lvl;
    typedef logic [ValW-1:0] t_val;
    typedef t_idx [RootSlots-1:0] t_roots;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    // trailing zeros of a level number, 0 for 0
    function automatic logic [2:0] f_tz(input t_lvl x);
        logic [2:0] n;
        n = 3'd0;
        if (x != '0) begin
            for (int i = LvlW - 1; i >= 0; i--) begin
                if (x[i]) n = 3'(i);
            end
        end
        return n;
    endfunction

    function automatic t_roots f_make_roots(input t_roots in, input t_lvl lvl, input t_idx node);
        t_roots o;
        logic [2:0] ri;
        ri = f_tz(lvl);
        for (int i = 0; i < RootSlots; i++) begin
            o[i] = (i <= int'(ri)) ? node : in[i];
        end
        return o;
    endfunction

    // child index; 33 bits is ample for all in-range offsets
    function automatic logic [32:0] f_child(input t_roots roots, input t_lvl lvl,
                                           input t_idx off, input logic dir);
        logic [2:0]  dt;
        logic [4:0]  sh;
        logic [32:0] amount;
        logic [32:0] span;
        logic [32:0] masked;
        logic [32:0] odd;
        logic [32:0] left;
        dt = f_tz(~lvl);
        if (~lvl == '0) dt = 3'd0;
        if (dt > 3'd4) dt = 3'd4;
        sh     = 5'd1 << dt;
        amount = 33'd1 << (sh - 5'd1);
        span   = (amount << 1) - 33'd1;
        masked = {17'd0, off} & (amount - 33'd1);
        odd    = (masked << 1) + 33'd1;
        // span is 2^sh - 1, so the product is a shift and a subtract
        left   = (odd << sh) - odd + {17'd0, roots[{1'b0, dt}]};
        return left + (dir ? span : 33'd0);
    endfunction
endpackage

// ----- design/veb_if.sv -----
// Valid/ready channel interface.
interface veb_if #(parameter int W = 32);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/veb_ram.sv -----
// Generic single-port RAM with registered read.
module veb_ram #(
    parameter int Width = 32,
    parameter int Depth = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- design/veb_layout_predecessor_search.sv -----
// Top level: vEB-layout store with load walker and predecessor search.
// Usage: input channel i_in carries {operation, value}; output channel o_out
// carries found_value for each search. Loads give no result.
// A load writes the store when it is taken, then the load walk climbs or
// descends one level per cycle until it stops (walk held in path registers).
// A search steps through S_RD and S_CMP for each tree level below the root,
// whose read is issued from S_IDLE; one node is read per level on the single
// RAM read port. element_count is written through i_cfg_we/i_cfg_wdata; the
// user must write it only while idle, the block does not enforce this; a write
// restarts the load walk. After reset (synchronous, active low) the count is
// 65535 and the walk starts; no clearing pass is made (store undefined).
// A finished result sits in the output register; when the receiver stalls
// the block holds it and takes no new item until it is taken.
module veb_layout_predecessor_search
    import veb_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_wdata,
    veb_if.sink             i_in,
    veb_if.source           o_out
);
    typedef enum logic [2:0] {
        S_WALK, S_IDLE, S_RD, S_CMP, S_OUT
    } t_state;

    t_state r_state;
    logic [CntW-1:0] r_count;
    t_idx   r_pos;
    t_idx   r_node  [MaxLevels];
    t_idx   r_off   [MaxLevels];
    t_roots r_roots [MaxLevels];
    t_lvl   r_top;
    logic   r_descend;
    t_val   r_key, r_res;
    t_lvl   r_slvl;
    t_idx   r_soff, r_snode;
    t_roots r_sroots;

    logic [CntW-1:0] cnt;
    logic ram_we;
    t_idx ram_addr;
    t_val ram_rdata;
    logic [32:0] cl, cr, cs;
    logic sright;
    t_roots snext;

    assign cnt = (r_count == 16'hFFFF) ? 16'hFFFF : r_count;

    veb_ram #(.Width(ValW), .Depth(1 << CapLog2)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(i_in.data[31:0]), .o_rdata(ram_rdata)
    );

    assign ram_we = (r_state == S_IDLE) && i_in.valid && !i_in.data[32] && cnt != 0;
    assign ram_addr = (r_state == S_IDLE) ? (i_in.data[32] ? t_idx'(0) : r_node[r_top])
                                          : r_snode;
    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.data = r_res;

    assign cl = f_child(r_roots[r_top], r_top, r_off[r_top], 1'b0);
    assign cr = f_child(r_roots[r_top], r_top, r_off[r_top], 1'b1);
    assign sright = $signed(ram_rdata) < $signed(r_key);
    assign snext = f_make_roots(r_sroots, r_slvl, r_snode);
    assign cs = f_child(snext, r_slvl, r_soff, sright);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            if (!i_rst_n) r_count <= 16'hFFFF;
            else r_count <= i_cfg_wdata;
            r_state <= S_WALK;
            r_pos <= '0;
            r_top <= '0;
            r_node[0] <= '0;
            r_off[0] <= '0;
            r_roots[0] <= f_make_roots('0, '0, '0);
            r_descend <= 1'b1;
        end else begin
            case (r_state)
                S_WALK: begin
                    if (r_descend) begin
                        // descend left one level per cycle
                        if (32'(r_top) + 1 < MaxLevels && cl < {17'd0, cnt}) begin
                            r_node[r_top+1] <= cl[IdxW-1:0];
                            r_off[r_top+1] <= r_off[r_top] << 1;
                            r_roots[r_top+1] <= f_make_roots(r_roots[r_top], r_top + 5'd1,
                                                            cl[IdxW-1:0]);
                            r_top <= r_top + 5'd1;
                        end else r_state <= S_IDLE;
                    end else begin
                        // climb past right-child frames
                        if (r_top > 0 && r_off[r_top][0]) r_top <= r_top - 5'd1;
                        else if (r_top > 0) begin
                            r_top <= r_top - 5'd1;
                            r_state <= S_IDLE;
                        end else begin
                            r_pos <= '0;
                            r_descend <= 1'b1;
                        end
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.data[32] == OP_SEARCH) begin
                            r_key <= i_in.data[31:0];
                            r_slvl <= '0; r_soff <= '0; r_snode <= '0;
                            r_sroots <= '0; r_res <= '0;
                            r_state <= (cnt == 0) ? S_OUT : S_CMP;
                        end else if (cnt != 0) begin
                            if (r_pos + 1'b1 >= cnt) begin
                                r_pos <= '0; r_top <= '0; r_descend <= 1'b1;
                                r_state <= S_WALK;
                            end else begin
                                r_pos <= r_pos + 1'b1;
                                if (cr < {17'd0, cnt} && 32'(r_top) + 1 < MaxLevels) begin
                                    r_node[r_top+1] <= cr[IdxW-1:0];
                                    r_off[r_top+1] <= (r_off[r_top] << 1) | t_idx'(1);
                                    r_roots[r_top+1] <= f_make_roots(r_roots[r_top],
                                                                    r_top + 5'd1,
                                                                    cr[IdxW-1:0]);
                                    r_top <= r_top + 5'd1;
                                    r_descend <= 1'b1;
                                    r_state <= S_WALK;
                                end else begin
                                    r_descend <= 1'b0;
                                    r_state <= S_WALK;
                                end
                            end
                        end
                    end
                end
                S_RD: r_state <= S_CMP;
                S_CMP: begin
                    if (ram_rdata == r_key) begin
                        r_res <= ram_rdata;
                        r_state <= S_OUT;
                    end else begin
                        if (sright) r_res <= ram_rdata;
                        if (cs >= {17'd0, cnt} || 32'(r_slvl) + 1 >= MaxLevels) r_state <= S_OUT;
                        else begin
                            r_sroots <= snext;
                            r_slvl <= r_slvl + 5'd1;
                            r_soff <= (r_soff << 1) | t_idx'(sright);
                            r_snode <= cs[IdxW-1:0];
                            r_state <= S_RD;
                        end
                    end
                end
                S_OUT: if (o_out.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "assert_macros.svh"
    `ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, (o_out.valid && !o_out.ready) |=> o_out.valid)
    `ASSERT_NEVER(a_no_ready_busy, i_clk, i_rst_n, i_in.ready && o_out.valid)
endmodule
